>>> rtl/vma_pkg.sv
// Shared types and constants of the velocity moving average unit.
package vma_pkg;

	// Field widths
	localparam int AXES    = 3;
	localparam int POS_W   = 32;
	localparam int DT_W    = 32;
	localparam int VEL_W   = 32;
	localparam int DIFF_W  = POS_W + 1;
	localparam int FRAC_W  = 16;
	localparam int WL_W    = 4;

	// Shared divider: 33-bit magnitude scaled by 2^16 over a 32-bit divisor
	localparam int DIV_W      = DIFF_W + FRAC_W;
	localparam int DIV_STEP_W = 6;
	localparam logic [DIV_STEP_W-1:0] RAW_STEPS = DIV_STEP_W'(DIV_W);

	// Saturation limits of a Q16.16 velocity
	localparam logic [VEL_W-1:0] VEL_MAX = 32'h7FFF_FFFF;
	localparam logic [VEL_W-1:0] VEL_MIN = 32'h8000_0000;
	localparam logic [DIV_W-1:0] QUO_POS_LIMIT = DIV_W'(33'h0_7FFF_FFFF);
	localparam logic [DIV_W-1:0] QUO_NEG_LIMIT = DIV_W'(33'h0_8000_0000);

	// Configuration port
	localparam int ADDR_W = 3;
	localparam logic [ADDR_W-3:0] REG_WINDOW = 1'b0;
	localparam logic [WL_W-1:0]  WINDOW_RESET = 4'd6;

	localparam logic [1:0] LAST_AXIS = 2'(AXES - 1);

	typedef struct packed {
		logic                  start;
		logic [DIV_W-1:0]      dividend;
		logic [DT_W-1:0]       divisor;
		logic [DIV_STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> rtl/vma_div.sv
// Radix-2 restoring divider shared by all quotients of the unit.
module vma_div (
	input  logic                clk,
	input  logic                arst_n,
	input  vma_pkg::div_req_t   req,
	output vma_pkg::div_rsp_t   rsp
);

	logic                             busy_q;
	logic                             done_q;
	logic [vma_pkg::DIV_STEP_W-1:0]   cnt_q;
	logic [vma_pkg::DT_W-1:0]         rem_q;
	logic [vma_pkg::DT_W-1:0]         dsor_q;
	logic [vma_pkg::DIV_W-1:0]        dd_q;

	logic [vma_pkg::DT_W:0]           rem_sh;
	logic                             ge;
	logic [vma_pkg::DT_W:0]           rem_sub;

	// One quotient bit per cycle
	always_comb begin
		rem_sh  = {rem_q, dd_q[vma_pkg::DIV_W-1]};
		ge      = rem_sh >= {1'b0, dsor_q};
		rem_sub = rem_sh - {1'b0, dsor_q};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == vma_pkg::DIV_STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath; the dividend register fills up with quotient bits
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			dsor_q <= req.divisor;
			dd_q   <= req.dividend;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[vma_pkg::DT_W-1:0] : rem_sh[vma_pkg::DT_W-1:0];
			dd_q  <= {dd_q[vma_pkg::DIV_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dd_q;

endmodule

>>> rtl/velocity_moving_average_unit.sv
// Top level: finite-difference velocity with a boxcar average per axis.
//
// Input stream s_*: one request per position sample (x, y, z) with the time
// step since the previous sample. Output stream m_*: one request per input,
// the smoothed velocity of the three axes and a saturation flag.
// The APB port holds window_length at byte address 0; a write empties the
// history. Write it only while the unit is idle.
// Timing: the unit takes one request at a time. Each raw velocity and each
// average runs through one shared radix-2 divider, one quotient bit per
// cycle: first the raw quotient of each axis (skipped for an axis with a
// zero time step), then the history update, then the average of each axis
// from its SUM_W-bit running sum, SUM_W = 32 + clog2(MAX_WINDOW). The first
// sample after reset skips the divider and returns zeros.
// The history is one memory row per slot holding all three axes, read when
// a request is taken and written back in the update cycle.
// Reset clears the window to 6, the history and the previous position.
// A stalled result sits in the output register; the unit finishes the
// following request up to the output register and waits there.
module velocity_moving_average_unit #(
	parameter int MAX_WINDOW = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// pos_x [31:0], pos_y [63:32], pos_z [95:64], time_step [127:96]
	input  logic [127:0]                s_tdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// vel_x [31:0], vel_y [63:32], vel_z [95:64]
	output logic [95:0]                 m_tdata,
	// saturated [0]
	output logic                        m_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [vma_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W  = vma_pkg::VEL_W + $clog2(MAX_WINDOW);
	localparam int ROW_W  = vma_pkg::AXES * vma_pkg::VEL_W;
	localparam logic [vma_pkg::DIV_STEP_W-1:0] SUM_STEPS = vma_pkg::DIV_STEP_W'(SUM_W);
	localparam logic [7:0] MAX8 = 8'(MAX_WINDOW);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RAW  = 3'd1;
	localparam logic [2:0] S_UPD  = 3'd2;
	localparam logic [2:0] S_AVG  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	// Control state
	logic [2:0]                    state_q;
	logic [1:0]                    axis_q;
	logic                          wait_q;
	logic                          first_q;
	logic [CNT_W-1:0]              fill_q;
	logic [IDX_W-1:0]              oldest_q;
	logic [vma_pkg::WL_W-1:0]      wl_q;
	logic [2:0][SUM_W-1:0]         sum_q;
	logic [2:0][vma_pkg::POS_W-1:0] prev_q;
	logic                          m_tvalid_q;

	// Payload
	logic [vma_pkg::DT_W-1:0]             dt_q;
	logic [2:0][vma_pkg::DIFF_W-1:0]      diff_mag_q;
	logic [2:0]                           diff_neg_q;
	logic [2:0][vma_pkg::VEL_W-1:0]       vel_q;
	logic                                 sat_q;
	logic                                 full_q;
	logic [IDX_W-1:0]                     slot_q;
	logic [95:0]                          m_tdata_q;
	logic                                 m_tuser_q;

	// History memory
	logic [ROW_W-1:0] hist_mem [MAX_WINDOW];
	logic [ROW_W-1:0] hist_rd_s1;

	logic                          s_acc;
	logic                          cfg_hit;
	logic                          cfg_wr;
	logic                          out_load;
	logic                          dt_zero;
	logic [7:0]                    w8;
	logic [7:0]                    fill8;
	logic [7:0]                    pos8;
	logic [7:0]                    slot8;
	logic [7:0]                    next8;
	logic                          full_nx;
	logic [IDX_W-1:0]              slot_nx;
	logic [2:0][vma_pkg::DIFF_W-1:0] diff_nx;
	logic [2:0][SUM_W-1:0]         sum_nx;
	logic [SUM_W-1:0]              sum_sel;
	logic [SUM_W-1:0]              sum_mag;
	logic [vma_pkg::DIFF_W-1:0]    mag_sel;
	logic                          neg_sel;
	logic [vma_pkg::VEL_W-1:0]     raw_vel;
	logic                          raw_sat;
	logic                          raw_take;
	logic [vma_pkg::VEL_W-1:0]     avg_vel;
	logic                          avg_take;
	logic                          axis_last;
	vma_pkg::div_req_t             div_req;
	vma_pkg::div_rsp_t             div_rsp;

	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign pready   = 1'b1;
	assign cfg_hit  = (paddr[vma_pkg::ADDR_W-1:2] == vma_pkg::REG_WINDOW);
	assign cfg_wr   = psel && penable && pwrite && pready && cfg_hit;
	assign prdata   = cfg_hit ? 32'(wl_q) : '0;
	assign out_load = (state_q == S_OUT) && (!m_tvalid_q || m_tready);
	assign dt_zero  = (dt_q == '0);
	assign axis_last = (axis_q == vma_pkg::LAST_AXIS);

	// Effective window and ring slot of the next sample
	always_comb begin
		if (wl_q == '0)
			w8 = 8'd1;
		else if (8'(wl_q) > MAX8)
			w8 = MAX8;
		else
			w8 = 8'(wl_q);
		fill8   = 8'(fill_q);
		full_nx = fill8 >= w8;
		pos8    = full_nx ? 8'(oldest_q) : 8'(oldest_q) + fill8;
		slot8   = (pos8 >= w8) ? pos8 - w8 : pos8;
		slot_nx = slot8[IDX_W-1:0];
		next8   = 8'(slot_q) + 8'd1;
	end

	// Position differences on the full 33 bits
	always_comb begin
		for (int a = 0; a < vma_pkg::AXES; a++) begin
			diff_nx[a] = vma_pkg::DIFF_W'($signed(s_tdata[a*vma_pkg::POS_W +: vma_pkg::POS_W]))
				- vma_pkg::DIFF_W'($signed(prev_q[a]));
		end
	end

	// Running sums after the new velocities enter and the oldest leave
	always_comb begin
		for (int a = 0; a < vma_pkg::AXES; a++) begin
			sum_nx[a] = sum_q[a] + SUM_W'($signed(vel_q[a]))
				- (full_q ? SUM_W'($signed(hist_rd_s1[a*vma_pkg::VEL_W +: vma_pkg::VEL_W]))
					: SUM_W'(0));
		end
	end

	// Divider operands
	always_comb begin
		mag_sel = diff_mag_q[axis_q];
		neg_sel = diff_neg_q[axis_q];
		sum_sel = sum_q[axis_q];
		sum_mag = sum_sel[SUM_W-1] ? -sum_sel : sum_sel;
		div_req.start = !wait_q && (((state_q == S_RAW) && !dt_zero) || (state_q == S_AVG));
		if (state_q == S_RAW) begin
			div_req.dividend = {mag_sel, {vma_pkg::FRAC_W{1'b0}}};
			div_req.divisor  = dt_q;
			div_req.steps    = vma_pkg::RAW_STEPS;
		end else begin
			div_req.dividend = vma_pkg::DIV_W'(sum_mag) << (vma_pkg::DIV_W - SUM_W);
			div_req.divisor  = vma_pkg::DT_W'(fill_q);
			div_req.steps    = SUM_STEPS;
		end
	end

	vma_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Raw velocity with saturation
	always_comb begin
		raw_sat = 1'b0;
		if (dt_zero) begin
			raw_sat = 1'b1;
			if (mag_sel == '0)
				raw_vel = '0;
			else
				raw_vel = neg_sel ? vma_pkg::VEL_MIN : vma_pkg::VEL_MAX;
		end else if (neg_sel) begin
			if (div_rsp.quotient > vma_pkg::QUO_NEG_LIMIT) begin
				raw_sat = 1'b1;
				raw_vel = vma_pkg::VEL_MIN;
			end else begin
				raw_vel = -div_rsp.quotient[vma_pkg::VEL_W-1:0];
			end
		end else if (div_rsp.quotient > vma_pkg::QUO_POS_LIMIT) begin
			raw_sat = 1'b1;
			raw_vel = vma_pkg::VEL_MAX;
		end else begin
			raw_vel = div_rsp.quotient[vma_pkg::VEL_W-1:0];
		end
	end

	// Average, truncated toward zero
	assign avg_vel  = sum_sel[SUM_W-1] ? -div_rsp.quotient[vma_pkg::VEL_W-1:0]
		: div_rsp.quotient[vma_pkg::VEL_W-1:0];
	assign raw_take = (state_q == S_RAW) && (dt_zero || (wait_q && div_rsp.done));
	assign avg_take = (state_q == S_AVG) && wait_q && div_rsp.done;

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			axis_q     <= '0;
			wait_q     <= 1'b0;
			first_q    <= 1'b1;
			fill_q     <= '0;
			oldest_q   <= '0;
			wl_q       <= vma_pkg::WINDOW_RESET;
			sum_q      <= '0;
			prev_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (div_req.start)
				wait_q <= 1'b1;
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						first_q <= 1'b0;
						axis_q  <= '0;
						for (int a = 0; a < vma_pkg::AXES; a++)
							prev_q[a] <= s_tdata[a*vma_pkg::POS_W +: vma_pkg::POS_W];
						state_q <= first_q ? S_OUT : S_RAW;
					end
				end
				S_RAW: begin
					if (raw_take) begin
						wait_q <= 1'b0;
						axis_q <= axis_last ? 2'd0 : axis_q + 2'd1;
						if (axis_last)
							state_q <= S_UPD;
					end
				end
				S_UPD: begin
					sum_q <= sum_nx;
					if (full_q)
						oldest_q <= (next8 == w8) ? '0 : next8[IDX_W-1:0];
					else
						fill_q <= fill_q + 1'b1;
					state_q <= S_AVG;
				end
				S_AVG: begin
					if (avg_take) begin
						wait_q <= 1'b0;
						axis_q <= axis_last ? 2'd0 : axis_q + 2'd1;
						if (axis_last)
							state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// Window write empties the history
			if (cfg_wr) begin
				wl_q     <= pwdata[vma_pkg::WL_W-1:0];
				sum_q    <= '0;
				fill_q   <= '0;
				oldest_q <= '0;
			end
			// Output register
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// Per-request payload
	always_ff @(posedge clk) begin
		if (s_acc) begin
			dt_q   <= s_tdata[127:96];
			full_q <= full_nx;
			slot_q <= slot_nx;
			sat_q  <= 1'b0;
			vel_q  <= '0;
			for (int a = 0; a < vma_pkg::AXES; a++) begin
				diff_neg_q[a] <= diff_nx[a][vma_pkg::DIFF_W-1];
				diff_mag_q[a] <= diff_nx[a][vma_pkg::DIFF_W-1] ? -diff_nx[a] : diff_nx[a];
			end
		end
		if (raw_take) begin
			vel_q[axis_q] <= raw_vel;
			sat_q         <= sat_q | raw_sat;
		end
		if (avg_take)
			vel_q[axis_q] <= avg_vel;
		if (out_load) begin
			m_tdata_q <= vel_q;
			m_tuser_q <= sat_q;
		end
	end

	// History: read the slot on acceptance, write it back in the update cycle
	always_ff @(posedge clk) begin
		if (s_acc)
			hist_rd_s1 <= hist_mem[slot_nx];
		if (state_q == S_UPD)
			hist_mem[slot_q] <= vel_q;
	end

	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tvalid = m_tvalid_q;

`ifndef ASSERT_OFF
	a_fill_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		fill8 <= w8)
		else $error("fill count exceeds window");
	a_oldest_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		8'(oldest_q) < w8)
		else $error("oldest index outside window");
	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> wait_q)
		else $error("divider result without a pending division");
	a_idle_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !wait_q)
		else $error("idle with a division pending");
	a_valid_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside the output state");
`endif

endmodule
